// File: src/tme_pkg.sv
// Package for the tape machine execute core: opcodes, field widths, result word.
`timescale 1ns / 1ps

package tme_pkg;

	// Defaults for the top-level parameters
	localparam int unsigned TAPE_DEPTH_DEF = 32768;
	localparam int unsigned PC_WIDTH_DEF   = 16;

	// Field widths of the input and result words
	localparam int unsigned OP_W      = 4;
	localparam int unsigned OPERAND_W = 17;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned NEXT_PC_W = 16;

	// Instruction codes; codes above OP_NOP behave as OP_NOP
	typedef enum logic [OP_W-1:0] {
		OP_MOVE   = 4'd0,
		OP_MUTATE = 4'd1,
		OP_IN     = 4'd2,
		OP_OUT    = 4'd3,
		OP_BRANCH = 4'd4,
		OP_JUMP   = 4'd5,
		OP_HALT   = 4'd6,
		OP_CLEAR  = 4'd7,
		OP_ADD    = 4'd8,
		OP_NOP    = 4'd9
	} op_t;

	// One result word
	typedef struct packed {
		logic                 halted;
		logic [BYTE_W-1:0]    out_byte;
		logic                 out_valid;
		logic [NEXT_PC_W-1:0] next_pc;
	} res_t;

endpackage

// File: src/tape_machine_execute.sv
// Execute core of a byte-tape machine with its tape memory and result buffer.
`timescale 1ns / 1ps

// Usage: the slave channel takes one fetched instruction per word (opcode,
// signed operand, input byte); the master channel returns one result word per
// instruction (next fetch address, halt state, output byte with its valid flag
// on tuser). Results come out in instruction order.
// Issue: a new instruction is taken only once the previous one has left its
// execute phase. Each instruction owns the single read port of the tape
// memory: the current cell is read first, and the add instruction then reads
// its target cell and writes it back, which can overlap the next instruction's
// current-cell read (forwarded on an address match).
// Result: the instruction is registered into stage 1 and executed there; its
// result word is then registered into the result buffer that drives m_tvalid.
// Reset: the pointer, program counter and halt flag clear at once; the tape is
// then zeroed one cell per cycle, all TAPE_DEPTH cells (32768 by default), while
// s_tready stays low. TAPE_DEPTH must be a power of two.
// Stall: a two-word result buffer lets one more instruction be accepted while a
// result waits; s_tready drops once both entries are held.
// After a halt, instructions are still taken and answered with the halted pc.
module tape_machine_execute #(
	parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF,
	parameter int unsigned PC_WIDTH   = tme_pkg::PC_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Instruction words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // op[3:0], operand[20:4], in_byte[28:21], zero[31:29]
	// Result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // next_pc[15:0], out_byte[23:16], halted[24], zero[31:25]
	output logic        m_tuser   // out_valid[0]
);

	localparam int unsigned TAPE_AW  = $clog2(TAPE_DEPTH);
	localparam int unsigned OPND_W   = tme_pkg::OPERAND_W;
	localparam int unsigned BYTE_W   = tme_pkg::BYTE_W;
	localparam int unsigned NPC_W    = tme_pkg::NEXT_PC_W;
	localparam int unsigned SUM_W    = ((TAPE_AW > OPND_W) ? TAPE_AW : OPND_W) + 1;
	localparam int unsigned PCX_W    = (PC_WIDTH > OPND_W) ? PC_WIDTH : OPND_W;
	localparam int unsigned RES_W    = $bits(tme_pkg::res_t);

	// Input word fields
	tme_pkg::op_t               in_op;
	logic signed [OPND_W-1:0]   in_operand;
	logic [BYTE_W-1:0]          in_byte;

	// Architectural state
	logic [TAPE_AW-1:0]         dp_q;
	logic [PC_WIDTH-1:0]        pc_q;
	logic                       stopped_q;

	// Tape clearing after reset
	logic                       clr_busy_q;
	logic [TAPE_AW-1:0]         clr_addr_q;

	// Stage 1: instruction in its execute phase
	logic                       ph_b_q;
	tme_pkg::op_t               op_s1;
	logic signed [OPND_W-1:0]   operand_s1;
	logic [BYTE_W-1:0]          in_byte_s1;
	logic [TAPE_AW-1:0]         t_s1;

	// Stage 2: add write-back
	logic                       add_c_q;
	logic [TAPE_AW-1:0]         t_s2;
	logic [BYTE_W-1:0]          cell_s2;

	// Tape memory and its ports
	logic [BYTE_W-1:0]          tape_mem [TAPE_DEPTH];
	logic [BYTE_W-1:0]          mem_rdata_q;
	logic [TAPE_AW-1:0]         mem_raddr;
	logic                       mem_we;
	logic [TAPE_AW-1:0]         mem_waddr;
	logic [BYTE_W-1:0]          mem_wdata;
	logic                       fwd_hit_q;
	logic [BYTE_W-1:0]          fwd_data_q;
	logic [BYTE_W-1:0]          rd_byte;

	// Execute results
	logic                       accept;
	logic [SUM_W-1:0]           idx_sum;
	logic [PCX_W-1:0]           opnd_pc;
	logic [PC_WIDTH-1:0]        pc_nxt;
	logic [TAPE_AW-1:0]         dp_nxt;
	logic                       stop_nxt;
	logic                       wr_b;
	logic [BYTE_W-1:0]          wr_b_data;
	logic                       add_go;
	logic                       emit_vld;
	logic [BYTE_W-1:0]          emit_byte;
	tme_pkg::res_t              res;

	// Result buffer
	tme_pkg::res_t              out_q;
	tme_pkg::res_t              skid_q;
	logic                       out_vld_q;
	logic                       skid_vld_q;
	logic                       pop;

	// Unpack the instruction word
	assign in_op      = tme_pkg::op_t'(s_tdata[3:0]);
	assign in_operand = s_tdata[20:4];
	assign in_byte    = s_tdata[28:21];

	// Take a word only outside an instruction's execute phase, with the tape cleared and a result slot free
	assign s_tready = !clr_busy_q && !ph_b_q && !skid_vld_q;
	assign accept   = s_tvalid && s_tready;

	// Wrap the pointer plus delta modulo the tape depth
	assign idx_sum = SUM_W'(dp_q) + SUM_W'(in_operand);

	// Read the current cell outside the execute phase, the add target during it
	assign mem_raddr = ph_b_q ? t_s1 : dp_q;

	// Forward a write that landed on the address read in the same cycle
	assign rd_byte = fwd_hit_q ? fwd_data_q : mem_rdata_q;

	// Pick the writer of the single write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dp_q;
		mem_wdata = wr_b_data;
		priority if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (add_c_q) begin
			mem_we    = 1'b1;
			mem_waddr = t_s2;
			mem_wdata = rd_byte + cell_s2;
		end else if (ph_b_q && wr_b) begin
			mem_we    = 1'b1;
		end else begin
			mem_we    = 1'b0;
		end
	end

	// Tape memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tape_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= tape_mem[mem_raddr];
	end

	// Remember a same-address write for the next cycle's read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= mem_we && (mem_waddr == mem_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= mem_wdata;
	end

	// Execute the instruction held in stage 1
	assign opnd_pc = PCX_W'(operand_s1);

	always_comb begin
		pc_nxt    = pc_q;
		dp_nxt    = dp_q;
		stop_nxt  = stopped_q;
		wr_b      = 1'b0;
		wr_b_data = rd_byte;
		add_go    = 1'b0;
		emit_vld  = 1'b0;
		emit_byte = '0;
		if (!stopped_q) begin
			pc_nxt = pc_q + PC_WIDTH'(1);
			unique case (op_s1)
				tme_pkg::OP_MOVE: begin
					dp_nxt = t_s1;
				end
				tme_pkg::OP_MUTATE: begin
					wr_b      = 1'b1;
					wr_b_data = rd_byte + operand_s1[BYTE_W-1:0];
				end
				tme_pkg::OP_IN: begin
					wr_b      = 1'b1;
					wr_b_data = in_byte_s1;
				end
				tme_pkg::OP_OUT: begin
					emit_vld  = 1'b1;
					emit_byte = rd_byte;
				end
				tme_pkg::OP_BRANCH: begin
					if (rd_byte == '0) begin
						pc_nxt = opnd_pc[PC_WIDTH-1:0];
					end
				end
				tme_pkg::OP_JUMP: begin
					pc_nxt = opnd_pc[PC_WIDTH-1:0];
				end
				tme_pkg::OP_HALT: begin
					stop_nxt = 1'b1;
					pc_nxt   = pc_q;
				end
				tme_pkg::OP_CLEAR: begin
					wr_b      = 1'b1;
					wr_b_data = '0;
				end
				tme_pkg::OP_ADD: begin
					add_go = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Build the result word
	always_comb begin
		res.next_pc   = NPC_W'(pc_nxt);
		res.out_valid = emit_vld;
		res.out_byte  = emit_byte;
		res.halted    = stop_nxt;
	end

	// Clear the tape after reset, one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + TAPE_AW'(1);
			if (clr_addr_q == TAPE_AW'(TAPE_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Advance the accept/execute sequence and the architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_b_q    <= 1'b0;
			add_c_q   <= 1'b0;
			dp_q      <= '0;
			pc_q      <= '0;
			stopped_q <= 1'b0;
		end else begin
			ph_b_q  <= accept;
			add_c_q <= ph_b_q && add_go;
			if (ph_b_q) begin
				dp_q      <= dp_nxt;
				pc_q      <= pc_nxt;
				stopped_q <= stop_nxt;
			end
		end
	end

	// Hold the instruction and the add operands
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= in_op;
			operand_s1 <= in_operand;
			in_byte_s1 <= in_byte;
			t_s1       <= idx_sum[TAPE_AW-1:0];
		end
		if (ph_b_q) begin
			t_s2    <= t_s1;
			cell_s2 <= rd_byte;
		end
	end

	// Two-entry result buffer: head register plus skid entry
	assign pop = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= ph_b_q;
			end else begin
				out_vld_q  <= ph_b_q;
				skid_vld_q <= 1'b0;
			end
		end else if (ph_b_q) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (ph_b_q) begin
			skid_q <= res;
		end
	end

	// Drive the result channel
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.out_valid;
	assign m_tdata  = {{(32 - RES_W + 1){1'b0}}, out_q.halted, out_q.out_byte, out_q.next_pc};

endmodule

// File: verif/tb.sv
// Self-checking testbench for the tape machine execute core: directed and random instruction words.
`timescale 1ns / 1ps

module tb;
	import tme_pkg::*;

	localparam int unsigned TAPE_DEPTH = TAPE_DEPTH_DEF;
	localparam int unsigned DP_W       = $clog2(TAPE_DEPTH);
	localparam int unsigned RAND_ITEMS = 1700;
	localparam int unsigned QUIET_TAIL = 150;
	localparam int unsigned DRAIN_WAIT = 20;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_SHOWN  = 10;

	// Opcodes outside the defined set; the core treats them as no-ops
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 4'd10;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 4'd15;

	// One instruction word, opcode in the lowest bits
	typedef struct packed {
		logic [BYTE_W-1:0]    in_byte;
		logic [OPERAND_W-1:0] operand;
		logic [OP_W-1:0]      op;
	} instr_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	tape_machine_execute dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Machine image kept alongside the core
	logic [BYTE_W-1:0]    tape_img [0:TAPE_DEPTH-1];
	logic [DP_W-1:0]      data_ptr = '0;
	logic [NEXT_PC_W-1:0] prog_ctr = '0;
	logic                 stopped  = 1'b0;

	instr_t pending_instrs[$];
	res_t   expected_results[$];

	logic        instr_taken = 1'b0;
	logic        idle_on = 1'b1;
	logic        quiet = 1'b0;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	int unsigned presented = 0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned bytes_out = 0;
	int unsigned branches_taken = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Execute one instruction on the image and return the result word it yields
	function automatic res_t step_machine(instr_t ins);
		res_t                 r;
		logic [DP_W-1:0]      offs;
		logic [DP_W-1:0]      tgt;
		logic [NEXT_PC_W-1:0] nxt;
		r    = '0;
		offs = ins.operand[DP_W-1:0];
		if (!stopped) begin
			nxt = prog_ctr + 1'b1;
			case (ins.op)
				OP_MOVE:   data_ptr = data_ptr + offs;
				OP_MUTATE: tape_img[data_ptr] = tape_img[data_ptr] + ins.operand[BYTE_W-1:0];
				OP_IN:     tape_img[data_ptr] = ins.in_byte;
				OP_OUT: begin
					r.out_valid = 1'b1;
					r.out_byte  = tape_img[data_ptr];
				end
				OP_BRANCH: begin
					if (tape_img[data_ptr] == '0) begin
						nxt = ins.operand[NEXT_PC_W-1:0];
						branches_taken++;
					end
				end
				OP_JUMP:  nxt = ins.operand[NEXT_PC_W-1:0];
				OP_HALT: begin
					stopped = 1'b1;
					nxt     = prog_ctr;
				end
				OP_CLEAR: tape_img[data_ptr] = '0;
				OP_ADD: begin
					tgt = data_ptr + offs;
					tape_img[tgt] = tape_img[tgt] + tape_img[data_ptr];
				end
				default: ;
			endcase
			prog_ctr = nxt;
		end
		r.next_pc = prog_ctr;
		r.halted  = stopped;
		return r;
	endfunction

	task automatic push_instr(input logic [OP_W-1:0] op, input int operand,
			input logic [BYTE_W-1:0] b);
		instr_t it;
		it.op      = op;
		it.operand = operand[OPERAND_W-1:0];
		it.in_byte = b;
		pending_instrs.push_back(it);
	endtask

	// Mostly small signed values so cells collide, plus full-range and edge operands
	function automatic int rand_operand();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k < 6)
			return int'($urandom_range(0, 6)) - 3;
		else if (k < 9)
			return int'($urandom_range(0, 17'h1FFFF));
		else begin
			case ($urandom_range(0, 3))
				0:       return 17'h0FFFF;
				1:       return -65536;
				2:       return -1;
				default: return 0;
			endcase
		end
	endfunction

	function automatic logic [OP_W-1:0] rand_op();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 15)      return OP_MOVE;
		else if (k < 30) return OP_MUTATE;
		else if (k < 40) return OP_IN;
		else if (k < 50) return OP_OUT;
		else if (k < 62) return OP_BRANCH;
		else if (k < 67) return OP_JUMP;
		else if (k < 77) return OP_CLEAR;
		else if (k < 90) return OP_ADD;
		else if (k < 95) return OP_NOP;
		else             return 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
	endfunction

	// Present instruction words; hold a word until it is taken
	always @(negedge clk) begin : drive_instr
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !instr_taken) begin
			s_tvalid <= 1'b1;
		end else if (in_gap > 0) begin
			in_gap   <= in_gap - 1;
			s_tvalid <= 1'b0;
		end else if (pending_instrs.size() == 0) begin
			s_tvalid <= 1'b0;
		end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
			in_gap   <= $urandom_range(0, 6);
			s_tvalid <= 1'b0;
		end else begin
			s_tdata   <= {3'b000, pending_instrs.pop_front()};
			s_tvalid  <= 1'b1;
			presented <= presented + 1;
			quiet     <= pending_instrs.size() < QUIET_TAIL;
			if (presented % 100 == 0)
				idle_on <= $urandom_range(0, 3) != 0;
		end
	end

	// Stall the result side in bursts
	always @(negedge clk) begin : drive_ready
		if (out_gap > 0) begin
			out_gap  <= out_gap - 1;
			m_tready <= 1'b0;
		end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
			out_gap  <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Predict on each accepted instruction, check each accepted result word
	always @(posedge clk) begin : check_results
		res_t exp_r;
		res_t got;
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_results.size());
			$display("FAILURE");
			$finish;
		end else begin
			instr_taken <= s_tvalid && s_tready;
			if (arst_n && m_tvalid && m_tready) begin
				got.next_pc   = m_tdata[15:0];
				got.out_byte  = m_tdata[23:16];
				got.halted    = m_tdata[24];
				got.out_valid = m_tuser;
				results_seen++;
				if (got.out_valid)
					bytes_out++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected result word %h tuser %b", m_tdata, m_tuser);
				end else begin
					exp_r = expected_results.pop_front();
					if (got.next_pc !== exp_r.next_pc || got.out_valid !== exp_r.out_valid ||
							got.out_byte !== exp_r.out_byte || got.halted !== exp_r.halted) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("result %0d: next_pc %h/%h out_valid %b/%b out_byte %h/%h halted %b/%b (exp/got)",
								results_seen, exp_r.next_pc, got.next_pc, exp_r.out_valid,
								got.out_valid, exp_r.out_byte, got.out_byte, exp_r.halted,
								got.halted);
					end
				end
			end
			if (arst_n && s_tvalid && s_tready)
				expected_results.push_back(step_machine(instr_t'(s_tdata[28:0])));
		end
	end

	initial begin : stimulus
		for (int i = 0; i < TAPE_DEPTH; i++)
			tape_img[i] = '0;

		// Directed: cell and pointer wrap, add onto itself, branch both ways, pc wrap
		push_instr(OP_NOP,    0,        8'h00);
		push_instr(OP_OUT,    0,        8'hFF);
		push_instr(OP_IN,     0,        8'hFF);
		push_instr(OP_OUT,    -1,       8'h00);
		push_instr(OP_MUTATE, 1,        8'h5A);
		push_instr(OP_OUT,    0,        8'h00);
		push_instr(OP_MUTATE, -1,       8'h00);
		push_instr(OP_MUTATE, 17'h0FFFF, 8'h00);
		push_instr(OP_MOVE,   -1,       8'h00);
		push_instr(OP_IN,     0,        8'hA5);
		push_instr(OP_MOVE,   1,        8'h00);
		push_instr(OP_MOVE,   -65536,   8'h00);
		push_instr(OP_MOVE,   17'h0FFFF, 8'h00);
		push_instr(OP_ADD,    1,        8'h00);
		push_instr(OP_ADD,    0,        8'h00);
		push_instr(OP_OUT,    0,        8'h00);
		push_instr(OP_BRANCH, 5,        8'h00);
		push_instr(OP_CLEAR,  0,        8'h00);
		push_instr(OP_BRANCH, -1,       8'h00);
		push_instr(OP_NOP,    0,        8'h00);
		push_instr(OP_JUMP,   -65536,   8'h00);
		push_instr(OP_JUMP,   17'h0FFFF, 8'h00);
		push_instr(OP_UNDEF_LO, 0,      8'h00);
		push_instr(OP_UNDEF_HI, -1,     8'hFF);

		for (int unsigned n = 0; n < RAND_ITEMS; n++)
			push_instr(rand_op(), rand_operand(), 8'($urandom_range(0, 255)));

		// Halt, then words that must be answered with the halted pc
		push_instr(OP_HALT, rand_operand(), 8'($urandom_range(0, 255)));
		push_instr(OP_OUT,  0,  8'h00);
		push_instr(OP_JUMP, 7,  8'h00);
		push_instr(OP_IN,   0,  8'h33);
		push_instr(OP_HALT, 0,  8'h00);
		push_instr(OP_OUT,  0,  8'h00);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_instrs.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d instruction words answered, %0d output bytes, %0d branches taken",
			results_seen, bytes_out, branches_taken);
		$display("mismatches: %0d, results left over: %0d", mismatches, expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
